### rtl/msd_pkg.sv
package msd_pkg;

   localparam int unsigned SAMPLE_W    = 24;
   localparam int unsigned MEAN_W      = 32;
   localparam int unsigned STDEV_W     = 32;
   localparam int unsigned TOTAL_W     = 13;
   localparam int unsigned RSP_TDATA_W = 80;
   localparam int unsigned RSP_PAD_W   = RSP_TDATA_W - MEAN_W - STDEV_W - TOTAL_W;

   localparam int unsigned DEF_MAX_SAMPLES   = 4096;
   localparam int unsigned DEF_SAMPLE_BITS   = 24;
   localparam int unsigned DEF_FRACTION_BITS = 8;

   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_SUB,
      BK_SQRT,
      BK_DIV_MEAN,
      BK_DIV_STD,
      BK_HOLD
   } back_state_type;

endpackage

### rtl/msd_front.sv
module msd_front #(
   parameter int unsigned MAX_SAMPLES = msd_pkg::DEF_MAX_SAMPLES,
   parameter int unsigned SAMPLE_BITS = msd_pkg::DEF_SAMPLE_BITS,
   parameter int unsigned CNT_W       = $clog2(MAX_SAMPLES + 1),
   parameter int unsigned SUM_W       = SAMPLE_BITS + CNT_W,
   parameter int unsigned SQ_W        = 2 * SAMPLE_BITS + CNT_W,
   parameter int unsigned SNAP_W      = CNT_W + SUM_W + SQ_W + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [msd_pkg::SAMPLE_W-1:0]  in_sample,
   input  logic                          in_last,
   output logic                          in_ready,
   output logic                          push_valid,
   output logic [SNAP_W-1:0]             push_data,
   input  logic                          push_space
);
   import msd_pkg::*;

   logic [CNT_W-1:0]         count_ff, count_in, count_upd;
   logic [SUM_W-1:0]         sum_ff, sum_in, sum_upd;
   logic [SQ_W-1:0]          sq_ff, sq_in, sq_upd;
   logic                     ovf_ff, ovf_in, ovf_upd;
   logic [SAMPLE_BITS-1:0]   sample;
   logic [2*SAMPLE_BITS-1:0] square;
   logic                     accept;
   logic                     full;

   assign in_ready = push_space;
   assign accept   = in_valid & in_ready;
   assign sample   = in_sample[SAMPLE_BITS-1:0];
   assign square   = (2 * SAMPLE_BITS)'(sample) * (2 * SAMPLE_BITS)'(sample);
   assign full     = (count_ff == CNT_W'(MAX_SAMPLES));

   always_comb begin
      count_upd = count_ff;
      sum_upd   = sum_ff;
      sq_upd    = sq_ff;
      ovf_upd   = ovf_ff;
      if (full) begin
         ovf_upd = 1'b1;
      end else begin
         count_upd = count_ff + CNT_W'(1);
         sum_upd   = sum_ff + SUM_W'(sample);
         sq_upd    = sq_ff + SQ_W'(square);
      end
   end

   assign push_valid = accept & in_last;
   assign push_data  = {ovf_upd, sq_upd, sum_upd, count_upd};

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      ovf_in   = ovf_ff;
      if (push_valid) begin
         count_in = '0;
         sum_in   = '0;
         sq_in    = '0;
         ovf_in   = 1'b0;
      end else if (accept) begin
         count_in = count_upd;
         sum_in   = sum_upd;
         sq_in    = sq_upd;
         ovf_in   = ovf_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
         ovf_ff   <= ovf_in;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count beyond limit");

   a_ovf_only_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> full)
      else $error("overflow flagged with count not full");
`endif

endmodule

### rtl/msd_queue.sv
module msd_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = msd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   input  logic [WIDTH-1:0] wr_data,
   output logic             wr_space,
   output logic             rd_valid,
   output logic [WIDTH-1:0] rd_data,
   input  logic             rd_ready
);
   import msd_pkg::*;

   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned FILL_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  mem_ff [DEPTH];
   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_wr, do_rd;

   assign wr_space = (fill_ff != FILL_W'(DEPTH));
   assign rd_valid = (fill_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_valid & wr_space;
   assign do_rd    = rd_valid & rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + ADDR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + ADDR_W'(1);
      end
      if (do_wr && !do_rd) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (!do_wr && do_rd) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef SYNTH
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      wr_valid |-> wr_space)
      else $error("snapshot pushed into full queue");
`endif

endmodule

### rtl/msd_back.sv
module msd_back #(
   parameter int unsigned MAX_SAMPLES   = msd_pkg::DEF_MAX_SAMPLES,
   parameter int unsigned SAMPLE_BITS   = msd_pkg::DEF_SAMPLE_BITS,
   parameter int unsigned FRACTION_BITS = msd_pkg::DEF_FRACTION_BITS,
   parameter int unsigned CNT_W         = $clog2(MAX_SAMPLES + 1),
   parameter int unsigned SUM_W         = SAMPLE_BITS + CNT_W,
   parameter int unsigned SQ_W          = 2 * SAMPLE_BITS + CNT_W,
   parameter int unsigned SNAP_W        = CNT_W + SUM_W + SQ_W + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  logic [SNAP_W-1:0]            q_data,
   output logic                         q_ready,
   output logic                         res_valid,
   output logic [msd_pkg::MEAN_W-1:0]   res_mean,
   output logic [msd_pkg::STDEV_W-1:0]  res_stdev,
   output logic [msd_pkg::TOTAL_W-1:0]  res_total,
   output logic                         res_ovf,
   input  logic                         res_ready
);
   import msd_pkg::*;

   localparam int unsigned PROD_W     = SQ_W + CNT_W;
   localparam int unsigned RAD_W      = PROD_W + 2 * FRACTION_BITS;
   localparam int unsigned ROOT_W     = (RAD_W + 1) / 2;
   localparam int unsigned RADP_W     = 2 * ROOT_W;
   localparam int unsigned REM_W      = ROOT_W + 2;
   localparam int unsigned MDVD_W     = SUM_W + FRACTION_BITS;
   localparam int unsigned DIV_W      = (MDVD_W > ROOT_W) ? MDVD_W : ROOT_W;
   localparam int unsigned MUL_STEPS  = SUM_W;
   localparam int unsigned MAX_STEPS0 = (MUL_STEPS > ROOT_W) ? MUL_STEPS : ROOT_W;
   localparam int unsigned MAX_STEPS  = (MAX_STEPS0 > DIV_W) ? MAX_STEPS0 : DIV_W;
   localparam int unsigned STEP_W     = $clog2(MAX_STEPS);

   back_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic              ovf_ff, ovf_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [PROD_W-1:0] mcand_a_ff, mcand_a_in, mcand_b_ff, mcand_b_in;
   logic [CNT_W-1:0]  mplr_a_ff, mplr_a_in;
   logic [SUM_W-1:0]  mplr_b_ff, mplr_b_in;
   logic [PROD_W-1:0] acc_a_ff, acc_a_in, acc_b_ff, acc_b_in;
   logic [RADP_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [DIV_W-1:0]  dvd_ff, dvd_in, quo_ff, quo_in;
   logic [CNT_W-1:0]  dr_ff, dr_in;
   logic [MEAN_W-1:0] mean_ff, mean_in;
   logic [STDEV_W-1:0] stdev_ff, stdev_in;

   logic [CNT_W-1:0]  q_n;
   logic [SUM_W-1:0]  q_sum;
   logic [SQ_W-1:0]   q_sq;
   logic              q_ovf;
   logic [PROD_W-1:0] diff;
   logic [REM_W+1:0]  rem_sh, trial;
   logic              sq_ge;
   logic [CNT_W:0]    dr_sh;
   logic              dv_ge;
   logic [DIV_W-1:0]  quo_next;

   assign {q_ovf, q_sq, q_sum, q_n} = q_data;

   assign diff     = acc_a_ff - acc_b_ff;
   assign rem_sh   = {rem_ff, rad_ff[RADP_W-1 -: 2]};
   assign trial    = (REM_W + 2)'({root_ff, 2'b01});
   assign sq_ge    = (rem_sh >= trial);
   assign dr_sh    = {dr_ff, dvd_ff[DIV_W-1]};
   assign dv_ge    = (dr_sh >= {1'b0, n_ff});
   assign quo_next = {quo_ff[DIV_W-2:0], dv_ge};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:     if (q_valid) state_in = BK_MUL;
         BK_MUL:      if (step_ff == '0) state_in = BK_SUB;
         BK_SUB:      state_in = BK_SQRT;
         BK_SQRT:     if (step_ff == '0) state_in = BK_DIV_MEAN;
         BK_DIV_MEAN: if (step_ff == '0) state_in = BK_DIV_STD;
         BK_DIV_STD:  if (step_ff == '0) state_in = BK_HOLD;
         BK_HOLD:     if (res_ready) state_in = BK_IDLE;
         default:     state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_ready   = 1'b0;
      res_valid = 1'b0;
      case (state_ff)
         BK_IDLE: q_ready   = 1'b1;
         BK_HOLD: res_valid = 1'b1;
         default: begin
            q_ready   = 1'b0;
            res_valid = 1'b0;
         end
      endcase
   end

   assign res_mean  = mean_ff;
   assign res_stdev = stdev_ff;
   assign res_total = TOTAL_W'(n_ff);
   assign res_ovf   = ovf_ff;

   // datapath
   always_comb begin
      step_in    = step_ff;
      n_in       = n_ff;
      ovf_in     = ovf_ff;
      sum_in     = sum_ff;
      mcand_a_in = mcand_a_ff;
      mcand_b_in = mcand_b_ff;
      mplr_a_in  = mplr_a_ff;
      mplr_b_in  = mplr_b_ff;
      acc_a_in   = acc_a_ff;
      acc_b_in   = acc_b_ff;
      rad_in     = rad_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      dvd_in     = dvd_ff;
      quo_in     = quo_ff;
      dr_in      = dr_ff;
      mean_in    = mean_ff;
      stdev_in   = stdev_ff;
      case (state_ff)
         BK_IDLE: begin
            n_in       = q_n;
            ovf_in     = q_ovf;
            sum_in     = q_sum;
            mcand_a_in = PROD_W'(q_sq);
            mcand_b_in = PROD_W'(q_sum);
            mplr_a_in  = q_n;
            mplr_b_in  = q_sum;
            acc_a_in   = '0;
            acc_b_in   = '0;
            step_in    = STEP_W'(MUL_STEPS - 1);
         end
         BK_MUL: begin
            if (mplr_a_ff[0]) acc_a_in = acc_a_ff + mcand_a_ff;
            if (mplr_b_ff[0]) acc_b_in = acc_b_ff + mcand_b_ff;
            mcand_a_in = mcand_a_ff << 1;
            mcand_b_in = mcand_b_ff << 1;
            mplr_a_in  = mplr_a_ff >> 1;
            mplr_b_in  = mplr_b_ff >> 1;
            step_in    = step_ff - STEP_W'(1);
         end
         BK_SUB: begin
            rad_in  = (acc_a_ff >= acc_b_ff) ?
                      (RADP_W'(diff) << (2 * FRACTION_BITS)) : '0;
            rem_in  = '0;
            root_in = '0;
            step_in = STEP_W'(ROOT_W - 1);
         end
         BK_SQRT: begin
            rad_in = rad_ff << 2;
            if (sq_ge) begin
               rem_in  = REM_W'(rem_sh - trial);
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = REM_W'(rem_sh);
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               dvd_in  = DIV_W'(sum_ff) << FRACTION_BITS;
               dr_in   = '0;
               quo_in  = '0;
               step_in = STEP_W'(DIV_W - 1);
            end
         end
         BK_DIV_MEAN, BK_DIV_STD: begin
            dvd_in  = dvd_ff << 1;
            dr_in   = dv_ge ? CNT_W'(dr_sh - {1'b0, n_ff}) : dr_sh[CNT_W-1:0];
            quo_in  = quo_next;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               if (state_ff == BK_DIV_MEAN) begin
                  mean_in = MEAN_W'(quo_next);
                  dvd_in  = DIV_W'(root_ff);
                  dr_in   = '0;
                  quo_in  = '0;
                  step_in = STEP_W'(DIV_W - 1);
               end else begin
                  stdev_in = STDEV_W'(quo_next);
               end
            end
         end
         default: begin
            step_in = step_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      n_ff       <= n_in;
      ovf_ff     <= ovf_in;
      sum_ff     <= sum_in;
      mcand_a_ff <= mcand_a_in;
      mcand_b_ff <= mcand_b_in;
      mplr_a_ff  <= mplr_a_in;
      mplr_b_ff  <= mplr_b_in;
      acc_a_ff   <= acc_a_in;
      acc_b_ff   <= acc_b_in;
      rad_ff     <= rad_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      dvd_ff     <= dvd_in;
      quo_ff     <= quo_in;
      dr_ff      <= dr_in;
      mean_ff    <= mean_in;
      stdev_ff   <= stdev_in;
   end

`ifndef SYNTH
   a_mul_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_MUL && step_ff == '0) |=> state_ff == BK_SUB)
      else $error("multiply phase did not hand over to subtract");

   a_sqrt_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_SQRT |-> rem_ff <= {1'b0, root_ff, 1'b0})
      else $error("root remainder exceeds twice the partial root");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV_MEAN || state_ff == BK_DIV_STD) |-> dr_ff < n_ff)
      else $error("divider remainder not below count");
`endif

endmodule

### rtl/mean_and_stdev_accumulator.sv
// Mean and population standard deviation over lists of unsigned samples.
// Input stream: req_tdata carries one sample per transaction, req_tlast marks
// the final sample of a list. Samples are accumulated at one per cycle while
// req_tready is high. Result stream: one transaction per list, mean =
// floor(sum*2^F/n) and stdev = floor(isqrt((n*sumsq - sum^2)*2^2F)/n), both
// with F fraction bits, plus the kept sample count and a flag for samples
// dropped past MAX_SAMPLES. A last sample pushes a snapshot of the sums into a
// two-entry queue; a sequencer then runs two parallel shift-add multiplies, a
// two-bit-per-step square root and two restoring divides. The back end takes
// one list at a time from the queue and starts the next once its result has
// moved to the output register.
// req_tready drops only while both queue entries hold lists not yet started.
// The result sits in an output register; while the receiver stalls it holds,
// the back end finishes the next list and waits, and sampling continues.
// Reset (synchronous) clears the running sums, the queue and the output valid.
module mean_and_stdev_accumulator #(
   parameter int unsigned MAX_SAMPLES   = msd_pkg::DEF_MAX_SAMPLES,
   parameter int unsigned SAMPLE_BITS   = msd_pkg::DEF_SAMPLE_BITS,
   parameter int unsigned FRACTION_BITS = msd_pkg::DEF_FRACTION_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [msd_pkg::SAMPLE_W-1:0]     req_tdata,   // [23:0] sample_value
   input  logic                             req_tlast,   // is_last
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] mean_fixed, [63:32] stdev_fixed, [76:64] sample_total, [79:77] zero
   output logic [msd_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tuser    // [0] overflowed
);
   import msd_pkg::*;

   localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int unsigned SUM_W  = SAMPLE_BITS + CNT_W;
   localparam int unsigned SQ_W   = 2 * SAMPLE_BITS + CNT_W;
   localparam int unsigned SNAP_W = CNT_W + SUM_W + SQ_W + 1;

   logic               push_valid, push_space;
   logic [SNAP_W-1:0]  push_data;
   logic               q_valid, q_ready;
   logic [SNAP_W-1:0]  q_data;
   logic               res_valid, res_ready, res_ovf;
   logic [MEAN_W-1:0]  res_mean;
   logic [STDEV_W-1:0] res_stdev;
   logic [TOTAL_W-1:0] res_total;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                   rsp_user_ff, rsp_user_in;

   msd_front #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CNT_W),
      .SUM_W       (SUM_W),
      .SQ_W        (SQ_W),
      .SNAP_W      (SNAP_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_sample  (req_tdata),
      .in_last    (req_tlast),
      .in_ready   (req_tready),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_space (push_space)
   );

   msd_queue #(
      .WIDTH (SNAP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_data  (push_data),
      .wr_space (push_space),
      .rd_valid (q_valid),
      .rd_data  (q_data),
      .rd_ready (q_ready)
   );

   msd_back #(
      .MAX_SAMPLES   (MAX_SAMPLES),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .CNT_W         (CNT_W),
      .SUM_W         (SUM_W),
      .SQ_W          (SQ_W),
      .SNAP_W        (SNAP_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_ready   (q_ready),
      .res_valid (res_valid),
      .res_mean  (res_mean),
      .res_stdev (res_stdev),
      .res_total (res_total),
      .res_ovf   (res_ovf),
      .res_ready (res_ready)
   );

   assign res_ready = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{RSP_PAD_W{1'b0}}, res_total, res_stdev, res_mean};
         rsp_user_in  = res_ovf;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
